// ===== rtl/core/lbcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_pkg: shared types and arithmetic for the lens coordinate map
// Fixed-point format, configuration and stage-to-stage structs, and the
// rounding and saturation helpers used by every pipeline section.
// ----------------------------------------------------------------------------
package lbcm_pkg;

  // Fixed-point format and map geometry
  localparam int FRAC_BITS  = 12;
  localparam int PIX_W      = 9;
  localparam int MAP_W_LOG2 = 9;
  localparam int MAP_H_LOG2 = 9;
  localparam int NRM_X_SH   = FRAC_BITS - MAP_W_LOG2;
  localparam int NRM_Y_SH   = FRAC_BITS - MAP_H_LOG2;
  localparam int NRM_X_W    = PIX_W + 1 + NRM_X_SH + 2;
  localparam int NRM_Y_W    = PIX_W + 1 + NRM_Y_SH + 2;
  localparam int CFG_AW     = 5;

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Configuration fields, already split into halves
  typedef struct packed {
    logic signed [15:0] k0;
    logic signed [15:0] k1;
    logic signed [15:0] k2;
    logic signed [15:0] k3;
    logic signed [15:0] red_scale;
    logic signed [15:0] red_slope;
    logic signed [15:0] blue_scale;
    logic signed [15:0] blue_slope;
    logic signed [15:0] shift;
    logic signed [15:0] aspect;
    logic signed [15:0] recip;
  } cfg_t;

  // Normalized position and squared radius
  typedef struct packed {
    logic signed [16:0] nx;
    logic signed [16:0] ny;
    logic signed [16:0] off;
    logic signed [20:0] r2;
  } nrm_t;

  // Position, barrel scale and per-channel chroma factors
  typedef struct packed {
    logic signed [16:0] nx;
    logic signed [16:0] ny;
    logic signed [16:0] off;
    logic signed [31:0] s;
    logic signed [31:0] c_red;
    logic signed [31:0] c_blue;
  } ply_t;

  // Result coordinates
  typedef struct packed {
    logic signed [15:0] red_u;
    logic signed [15:0] red_v;
    logic signed [15:0] blue_u;
    logic signed [15:0] blue_v;
  } res_t;

  // Round a raw product half up, drop the fraction, clamp to 32 bits
  function automatic logic signed [31:0] rnd_sat32(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + HALF) >>> FRAC_BITS;
    if (t[63:31] == '0 || t[63:31] == '1) begin
      rnd_sat32 = t[31:0];
    end else begin
      rnd_sat32 = t[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  endfunction

  // Clamp a 33-bit sum to 32 bits
  function automatic logic signed [31:0] sat_32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat_32 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_32 = v[31:0];
    end
  endfunction

  // Map -1..1 to 0..1 (floor halving) and clamp to 16 bits
  function automatic logic signed [15:0] out_fix(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [32:0] h;
    t = 33'(v) + 33'(ONE);
    h = t >>> 1;
    if (h[32:15] == '0 || h[32:15] == '1) begin
      out_fix = h[15:0];
    end else begin
      out_fix = h[32] ? 16'sh8000 : 16'sh7fff;
    end
  endfunction

endpackage

// ===== rtl/core/lbcm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_in_if: pixel request channel
// Carries one output pixel position and eye select per transfer.
// ----------------------------------------------------------------------------
interface lbcm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        eye_sel;
  logic [lbcm_pkg::PIX_W-1:0]  pixel_x;
  logic [lbcm_pkg::PIX_W-1:0]  pixel_y;

  modport source (output valid, eye_sel, pixel_x, pixel_y, input ready);
  modport sink   (input valid, eye_sel, pixel_x, pixel_y, output ready);
endinterface

// ===== rtl/core/lbcm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_out_if: source coordinate channel
// Carries the red and blue source coordinates of one pixel per transfer.
// ----------------------------------------------------------------------------
interface lbcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red_u;
  logic signed [15:0] red_v;
  logic signed [15:0] blue_u;
  logic signed [15:0] blue_v;

  modport source (output valid, red_u, red_v, blue_u, blue_v, input ready);
  modport sink   (input valid, red_u, red_v, blue_u, blue_v, output ready);
endinterface

// ===== rtl/core/lbcm_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_norm: pixel normalization and squared radius
// Two stages: map the pixel centre to -1..1 with aspect and lens offset,
// then square and sum the two axes.
// ----------------------------------------------------------------------------
module lbcm_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lbcm_pkg::cfg_t             cfg,
  input  logic                       up_vld,
  output logic                       up_rdy,
  input  logic                       eye_sel,
  input  logic [lbcm_pkg::PIX_W-1:0] pixel_x,
  input  logic [lbcm_pkg::PIX_W-1:0] pixel_y,
  output logic                       dn_vld,
  input  logic                       dn_rdy,
  output lbcm_pkg::nrm_t             dn
);

  logic [1:0] vld_r;
  logic [1:0] en;

  logic signed [lbcm_pkg::NRM_X_W-1:0] nx0;
  logic signed [lbcm_pkg::NRM_Y_W-1:0] ny0;
  logic signed [16:0]                  off_nxt;
  logic signed [17:0]                  nx_sum;
  logic signed [16:0]                  nx_nxt;
  logic signed [30:0]                  ny_prod;
  logic signed [31:0]                  ny_rnd;
  logic signed [16:0]                  ny_nxt;

  logic signed [16:0] nx_r;
  logic signed [16:0] ny_r;
  logic signed [16:0] off_r;

  logic signed [33:0] sqx_prod;
  logic signed [33:0] sqy_prod;
  logic signed [31:0] sqx;
  logic signed [31:0] sqy;
  lbcm_pkg::nrm_t     dn_nxt;
  lbcm_pkg::nrm_t     dn_r;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[1] = !vld_r[1] || dn_rdy;
    en[0] = !vld_r[0] || en[1];
  end

  assign up_rdy = en[0];
  assign dn_vld = vld_r[1];
  assign dn     = dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  // Stage 1: pixel centre to -1..1, lens offset, vertical aspect
  always_comb begin
    nx0 = $signed({2'b00, pixel_x, 1'b1, {lbcm_pkg::NRM_X_SH{1'b0}}})
          - lbcm_pkg::NRM_X_W'(lbcm_pkg::ONE);
    ny0 = $signed({2'b00, pixel_y, 1'b1, {lbcm_pkg::NRM_Y_SH{1'b0}}})
          - lbcm_pkg::NRM_Y_W'(lbcm_pkg::ONE);
    off_nxt = eye_sel ? 17'(cfg.shift) : -17'(cfg.shift);
    nx_sum  = 18'(nx0) + 18'(off_nxt);
    nx_nxt  = nx_sum[16:0];
    ny_prod = ny0 * cfg.recip;
    ny_rnd  = lbcm_pkg::rnd_sat32(64'(ny_prod));
    ny_nxt  = ny_rnd[16:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      off_r <= off_nxt;
    end
  end

  // Stage 2: squared radius
  always_comb begin
    sqx_prod   = nx_r * nx_r;
    sqy_prod   = ny_r * ny_r;
    sqx        = lbcm_pkg::rnd_sat32(64'(sqx_prod));
    sqy        = lbcm_pkg::rnd_sat32(64'(sqy_prod));
    dn_nxt.nx  = nx_r;
    dn_nxt.ny  = ny_r;
    dn_nxt.off = off_r;
    dn_nxt.r2  = 21'(sqx + sqy);
  end

  always_ff @(posedge clk) begin
    if (en[1]) dn_r <= dn_nxt;
  end

endmodule

// ===== rtl/core/lbcm_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_poly: barrel polynomial and chroma factors
// Three stages, one Horner step each; the linear chroma factors for red
// and blue are formed in the first stage and carried along.
// ----------------------------------------------------------------------------
module lbcm_poly (
  input  logic           clk,
  input  logic           rst_n,
  input  lbcm_pkg::cfg_t cfg,
  input  logic           up_vld,
  output logic           up_rdy,
  input  lbcm_pkg::nrm_t up,
  output logic           dn_vld,
  input  logic           dn_rdy,
  output lbcm_pkg::ply_t dn
);

  typedef struct packed {
    lbcm_pkg::nrm_t     pos;
    logic signed [31:0] s;
    logic signed [31:0] c_red;
    logic signed [31:0] c_blue;
  } hrn_t;

  logic [2:0] vld_r;
  logic [2:0] en;
  hrn_t       st_r   [3];
  hrn_t       st_nxt [3];

  logic signed [36:0] p_k3;
  logic signed [52:0] p_s1;
  logic signed [52:0] p_s2;
  logic signed [36:0] p_red;
  logic signed [36:0] p_blue;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[2] = !vld_r[2] || dn_rdy;
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign up_rdy = en[0];
  assign dn_vld = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // Horner steps: k2 + r2*k3, then k1 + r2*s, then k0 + r2*s
  always_comb begin
    p_k3   = up.r2 * cfg.k3;
    p_red  = cfg.red_slope * up.r2;
    p_blue = cfg.blue_slope * up.r2;
    st_nxt[0].pos    = up;
    st_nxt[0].s      = lbcm_pkg::sat_32(33'(cfg.k2)
                       + 33'(lbcm_pkg::rnd_sat32(64'(p_k3))));
    st_nxt[0].c_red  = lbcm_pkg::sat_32(33'(cfg.red_scale)
                       + 33'(lbcm_pkg::rnd_sat32(64'(p_red))));
    st_nxt[0].c_blue = lbcm_pkg::sat_32(33'(cfg.blue_scale)
                       + 33'(lbcm_pkg::rnd_sat32(64'(p_blue))));

    p_s1      = st_r[0].pos.r2 * st_r[0].s;
    st_nxt[1] = st_r[0];
    st_nxt[1].s = lbcm_pkg::sat_32(33'(cfg.k1)
                  + 33'(lbcm_pkg::rnd_sat32(64'(p_s1))));

    p_s2      = st_r[1].pos.r2 * st_r[1].s;
    st_nxt[2] = st_r[1];
    st_nxt[2].s = lbcm_pkg::sat_32(33'(cfg.k0)
                  + 33'(lbcm_pkg::rnd_sat32(64'(p_s2))));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (en[i]) st_r[i] <= st_nxt[i];
    end
  end

  // Drop the radius, hand on the rest
  always_comb begin
    dn.nx     = st_r[2].pos.nx;
    dn.ny     = st_r[2].pos.ny;
    dn.off    = st_r[2].pos.off;
    dn.s      = st_r[2].s;
    dn.c_red  = st_r[2].c_red;
    dn.c_blue = st_r[2].c_blue;
  end

endmodule

// ===== rtl/core/lbcm_chroma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcm_chroma: distortion, per-channel chroma scaling and output mapping
// Three stages: scale the position by the barrel factor, apply the red and
// blue chroma factors, then undo offset and aspect into the output register.
// ----------------------------------------------------------------------------
module lbcm_chroma (
  input  logic           clk,
  input  logic           rst_n,
  input  lbcm_pkg::cfg_t cfg,
  input  logic           up_vld,
  output logic           up_rdy,
  input  lbcm_pkg::ply_t up,
  output logic           dn_vld,
  input  logic           dn_rdy,
  output lbcm_pkg::res_t dn
);

  logic [2:0] vld_r;
  logic [2:0] en;

  // Stage 1 products and registers
  logic signed [48:0] p_dx;
  logic signed [48:0] p_dy;
  logic signed [31:0] dx_r;
  logic signed [31:0] dy_r;
  logic signed [31:0] cr1_r;
  logic signed [31:0] cb1_r;
  logic signed [16:0] off1_r;

  // Stage 2 products and registers
  logic signed [63:0] p_rx;
  logic signed [63:0] p_ry;
  logic signed [63:0] p_bx;
  logic signed [63:0] p_by;
  logic signed [31:0] rx_r;
  logic signed [31:0] ry_r;
  logic signed [31:0] bx_r;
  logic signed [31:0] by_r;
  logic signed [16:0] off2_r;

  // Stage 3
  logic signed [47:0] p_ra;
  logic signed [47:0] p_ba;
  logic signed [31:0] red_x;
  logic signed [31:0] blue_x;
  lbcm_pkg::res_t     res_nxt;
  lbcm_pkg::res_t     res_r;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[2] = !vld_r[2] || dn_rdy;
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign up_rdy = en[0];
  assign dn_vld = vld_r[2];
  assign dn     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // Stage 1: barrel-distorted position
  always_comb begin
    p_dx = up.nx * up.s;
    p_dy = up.ny * up.s;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r   <= lbcm_pkg::rnd_sat32(64'(p_dx));
      dy_r   <= lbcm_pkg::rnd_sat32(64'(p_dy));
      cr1_r  <= up.c_red;
      cb1_r  <= up.c_blue;
      off1_r <= up.off;
    end
  end

  // Stage 2: chroma scale per channel
  always_comb begin
    p_rx = dx_r * cr1_r;
    p_ry = dy_r * cr1_r;
    p_bx = dx_r * cb1_r;
    p_by = dy_r * cb1_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rx_r   <= lbcm_pkg::rnd_sat32(p_rx);
      ry_r   <= lbcm_pkg::rnd_sat32(p_ry);
      bx_r   <= lbcm_pkg::rnd_sat32(p_bx);
      by_r   <= lbcm_pkg::rnd_sat32(p_by);
      off2_r <= off1_r;
    end
  end

  // Stage 3: undo offset and aspect, map to 0..1, saturate
  always_comb begin
    p_ra   = ry_r * cfg.aspect;
    p_ba   = by_r * cfg.aspect;
    red_x  = lbcm_pkg::sat_32(33'(rx_r) - 33'(off2_r));
    blue_x = lbcm_pkg::sat_32(33'(bx_r) - 33'(off2_r));
    res_nxt.red_u  = lbcm_pkg::out_fix(red_x);
    res_nxt.red_v  = lbcm_pkg::out_fix(lbcm_pkg::rnd_sat32(64'(p_ra)));
    res_nxt.blue_u = lbcm_pkg::out_fix(blue_x);
    res_nxt.blue_v = lbcm_pkg::out_fix(lbcm_pkg::rnd_sat32(64'(p_ba)));
  end

  always_ff @(posedge clk) begin
    if (en[2]) res_r <= res_nxt;
  end

endmodule

// ===== rtl/core/lens_barrel_chroma_coord_map_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_barrel_chroma_coord_map_unit: lens distortion coordinate map
// Maps each output pixel to red and blue source coordinates with a cubic
// barrel polynomial and a linear chroma correction, in Q4.12.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   valid/ready channel, one pixel (eye_sel, pixel_x, pixel_y) per
//           transfer.
//   out_ch  valid/ready channel, one result (red_u, red_v, blue_u, blue_v)
//           per input transfer, in input order.
//   APB     registers at byte address 4*i: k_coef0..3, red_chroma,
//           blue_chroma, lens_shift, aspect_pair. Write only while no pixel
//           is in flight. pready is always high; reads return the register.
// Pipeline: eight register stages (normalize 2, polynomial 3, chroma and
//   output 3); a result is offered on out_ch from the last stage, the
//   output register.
// Throughput: one pixel per clock while out_ch.ready is high, set by the fully pipelined multipliers.
// Stall: each stage holds while the next is full and stalled, so bubbles
//   fill up before in_ch.ready drops; the last stage is the output register.
// Reset: rst_n (synchronous) empties the pipeline and loads the register
//   defaults (unit polynomial, unit chroma scale, no offset, unit aspect).
// ----------------------------------------------------------------------------
module lens_barrel_chroma_coord_map_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lbcm_in_if.sink                       in_ch,
  lbcm_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbcm_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [2:0] REG_K_COEF0     = 3'd0;
  localparam logic [2:0] REG_K_COEF1     = 3'd1;
  localparam logic [2:0] REG_K_COEF2     = 3'd2;
  localparam logic [2:0] REG_K_COEF3     = 3'd3;
  localparam logic [2:0] REG_RED_CHROMA  = 3'd4;
  localparam logic [2:0] REG_BLUE_CHROMA = 3'd5;
  localparam logic [2:0] REG_LENS_SHIFT  = 3'd6;
  localparam logic [2:0] REG_ASPECT_PAIR = 3'd7;

  logic [15:0] k_coef0_r;
  logic [15:0] k_coef1_r;
  logic [15:0] k_coef2_r;
  logic [15:0] k_coef3_r;
  logic [31:0] red_chroma_r;
  logic [31:0] blue_chroma_r;
  logic [15:0] lens_shift_r;
  logic [31:0] aspect_pair_r;

  logic [2:0]     reg_idx;
  logic           wr_en;
  lbcm_pkg::cfg_t cfg;

  logic           nrm_vld;
  logic           nrm_rdy;
  lbcm_pkg::nrm_t nrm;
  logic           ply_vld;
  logic           ply_rdy;
  lbcm_pkg::ply_t ply;
  lbcm_pkg::res_t res;

  // Register file write on the access phase
  assign reg_idx = paddr[lbcm_pkg::CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_coef0_r     <= 16'h1000;
      k_coef1_r     <= '0;
      k_coef2_r     <= '0;
      k_coef3_r     <= '0;
      red_chroma_r  <= 32'h1000_0000;
      blue_chroma_r <= 32'h1000_0000;
      lens_shift_r  <= '0;
      aspect_pair_r <= 32'h1000_1000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_K_COEF0:     k_coef0_r     <= pwdata[15:0];
        REG_K_COEF1:     k_coef1_r     <= pwdata[15:0];
        REG_K_COEF2:     k_coef2_r     <= pwdata[15:0];
        REG_K_COEF3:     k_coef3_r     <= pwdata[15:0];
        REG_RED_CHROMA:  red_chroma_r  <= pwdata;
        REG_BLUE_CHROMA: blue_chroma_r <= pwdata;
        REG_LENS_SHIFT:  lens_shift_r  <= pwdata[15:0];
        REG_ASPECT_PAIR: aspect_pair_r <= pwdata;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_idx)
      REG_K_COEF0:     prdata = {16'h0000, k_coef0_r};
      REG_K_COEF1:     prdata = {16'h0000, k_coef1_r};
      REG_K_COEF2:     prdata = {16'h0000, k_coef2_r};
      REG_K_COEF3:     prdata = {16'h0000, k_coef3_r};
      REG_RED_CHROMA:  prdata = red_chroma_r;
      REG_BLUE_CHROMA: prdata = blue_chroma_r;
      REG_LENS_SHIFT:  prdata = {16'h0000, lens_shift_r};
      REG_ASPECT_PAIR: prdata = aspect_pair_r;
    endcase
  end

  // Split packed registers into signed fields
  always_comb begin
    cfg.k0         = k_coef0_r;
    cfg.k1         = k_coef1_r;
    cfg.k2         = k_coef2_r;
    cfg.k3         = k_coef3_r;
    cfg.red_scale  = red_chroma_r[31:16];
    cfg.red_slope  = red_chroma_r[15:0];
    cfg.blue_scale = blue_chroma_r[31:16];
    cfg.blue_slope = blue_chroma_r[15:0];
    cfg.shift      = lens_shift_r;
    cfg.aspect     = aspect_pair_r[31:16];
    cfg.recip      = aspect_pair_r[15:0];
  end

  // Pipeline sections
  lbcm_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .up_vld  (in_ch.valid),
    .up_rdy  (in_ch.ready),
    .eye_sel (in_ch.eye_sel),
    .pixel_x (in_ch.pixel_x),
    .pixel_y (in_ch.pixel_y),
    .dn_vld  (nrm_vld),
    .dn_rdy  (nrm_rdy),
    .dn      (nrm)
  );

  lbcm_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .up_vld (nrm_vld),
    .up_rdy (nrm_rdy),
    .up     (nrm),
    .dn_vld (ply_vld),
    .dn_rdy (ply_rdy),
    .dn     (ply)
  );

  lbcm_chroma u_chroma (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .up_vld (ply_vld),
    .up_rdy (ply_rdy),
    .up     (ply),
    .dn_vld (out_ch.valid),
    .dn_rdy (out_ch.ready),
    .dn     (res)
  );

  // Drive the result channel payload
  assign out_ch.red_u  = res.red_u;
  assign out_ch.red_v  = res.red_v;
  assign out_ch.blue_u = res.blue_u;
  assign out_ch.blue_v = res.blue_v;

endmodule
